// File: rtl/positional_insert_erase_list_unit_defines.svh
// Assertion macros for the positional list unit.
`ifndef POSITIONAL_INSERT_ERASE_LIST_UNIT_DEFINES_SVH
`define POSITIONAL_INSERT_ERASE_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define PIE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define PIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pie_pkg.sv
package pie_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;

    typedef enum logic [2:0] {
        REQ_INSERT = 3'd0,
        REQ_ERASE  = 3'd1,
        REQ_PUSH   = 3'd2,
        REQ_POP    = 3'd3,
        REQ_READ   = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic             ins;
        logic             ers;
        logic [LEN_W-1:0] pos;
    } pie_ctl_t;

endpackage

// File: rtl/positional_insert_erase_list_unit.sv
// Channel  | Group                      | Contents
// request  | s_tvalid s_tready s_tdata  | s_tuser: req_type; s_tdata: position, value
// result   | m_tvalid m_tready m_tdata  | m_tuser: status;   m_tdata: data, count
//
// One request per cycle while results are taken; its result is written into the
// output register in the cycle after the transfer. Every cell of the chain shifts
// in the same cycle, so insert and erase cost the same as read. Reset clears the
// length and output valid; the cell contents stay undefined until written. While
// a result waits untaken the input is held off.
module positional_insert_erase_list_unit
    import pie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [6:0] position, [38:7] value, [39] zero
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] data, [38:32] count, [39] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic                    accept;
    req_t                    req;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic [CMP_W-1:0]        pos_c;
    logic [CMP_W-1:0]        len_c;

    logic [LEN_W-1:0]        len_reg;
    logic [LEN_W-1:0]        len_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    status_t                 status_reg;
    status_t                 status_next;
    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;

    status_t                 st;
    logic                    ins_ok;
    logic                    ers_ok;
    logic                    want_data;
    logic [LEN_W-1:0]        eff_pos;
    pie_ctl_t                ctl;

    logic signed [VAL_W-1:0] cell_q   [CAPACITY];
    logic signed [VAL_W-1:0] cell_hit [CAPACITY];
    logic [CAPACITY-1:0]     hit_col  [VAL_W];
    logic [VAL_W-1:0]        sel_data;

    assign req      = req_t'(s_tuser);
    assign position = s_tdata[POS_W-1:0];
    assign value    = s_tdata[POS_W+VAL_W-1:POS_W];
    assign pos_c    = CMP_W'(position);
    assign len_c    = CMP_W'(len_reg);

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Decode request into status and the cell command
    always_comb
    begin
        st        = ST_OK;
        ins_ok    = 1'b0;
        ers_ok    = 1'b0;
        want_data = 1'b0;
        eff_pos   = LEN_W'(position);
        case (req)
            REQ_INSERT:
            begin
                if (pos_c > len_c)
                    st = ST_RANGE;
                else if (len_reg >= LEN_W'(CAPACITY))
                    st = ST_FULL;
                else
                    ins_ok = 1'b1;
            end
            REQ_PUSH:
            begin
                eff_pos = len_reg;
                if (len_reg >= LEN_W'(CAPACITY))
                    st = ST_FULL;
                else
                    ins_ok = 1'b1;
            end
            REQ_ERASE, REQ_READ:
            begin
                if (len_reg == '0)
                    st = ST_EMPTY;
                else if (pos_c >= len_c)
                    st = ST_RANGE;
                else
                begin
                    want_data = 1'b1;
                    ers_ok    = (req == REQ_ERASE);
                end
            end
            REQ_POP:
            begin
                eff_pos = len_reg - LEN_W'(1);
                if (len_reg == '0)
                    st = ST_EMPTY;
                else
                begin
                    want_data = 1'b1;
                    ers_ok    = 1'b1;
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    assign ctl.ins = accept && ins_ok;
    assign ctl.ers = accept && ers_ok;
    assign ctl.pos = eff_pos;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [VAL_W-1:0] left_w;
            logic signed [VAL_W-1:0] right_w;
            if (g == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = cell_q[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = cell_q[g+1];
            end
            pie_cell u_cell (
                .clk   (clk),
                .idx   (IDX_W'(g)),
                .ctl   (ctl),
                .value (value),
                .left  (left_w),
                .right (right_w),
                .q     (cell_q[g]),
                .hit   (cell_hit[g])
            );
        end
    endgenerate

    // At most one cell matches; OR each bit column
    always_comb
    begin
        for (int b = 0; b < VAL_W; b++)
        begin
            for (int c = 0; c < CAPACITY; c++)
                hit_col[b][c] = cell_hit[c][b];
        end
    end

    always_comb
    begin
        for (int b = 0; b < VAL_W; b++)
            sel_data[b] = |hit_col[b];
    end

    always_comb
    begin
        len_next       = len_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = st;
            data_next      = want_data ? sel_data : '0;
            if (ins_ok)
                len_next = len_reg + LEN_W'(1);
            else if (ers_ok)
                len_next = len_reg - LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
    end

    logic [LEN_W-1:0] count_reg;
    always_ff @(posedge clk)
    begin
        if (accept)
            count_reg <= len_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = 40'({POS_W'(count_reg), data_reg});

endmodule

// File: rtl/pie_cell.sv
module pie_cell
    import pie_pkg::*;
(
    input  logic                    clk,
    input  logic [IDX_W-1:0]        idx,
    input  pie_ctl_t                ctl,
    input  logic signed [VAL_W-1:0] value,
    input  logic signed [VAL_W-1:0] left,
    input  logic signed [VAL_W-1:0] right,
    output logic signed [VAL_W-1:0] q,
    output logic signed [VAL_W-1:0] hit
);

    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;
    logic [LEN_W-1:0]        my_idx;

    assign my_idx = LEN_W'(idx);

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (my_idx > ctl.pos)
                data_next = left;
            else if (my_idx == ctl.pos)
                data_next = value;
        end
        else if (ctl.ers)
        begin
            // close the gap: take the neighbour above
            if (my_idx >= ctl.pos)
                data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q   = data_reg;
    assign hit = (my_idx == ctl.pos) ? data_reg : '0;

endmodule

// File: rtl/pie_checker.sv
`include "positional_insert_erase_list_unit_defines.svh"

module pie_checker
    import pie_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `PIE_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `PIE_ASSERT_NOW(a_err_zero, m_tvalid && (m_tuser != ST_OK), m_tdata[31:0] == 32'd0, "error result carries data")
    `PIE_ASSERT_NOW(a_count_cap, m_tvalid, m_tdata[38:32] <= 7'(CAPACITY), "count above capacity")
    `PIE_ASSERT_NEXT(a_result_follows, s_tvalid && s_tready, m_tvalid, "no result after transfer")

endmodule

bind positional_insert_erase_list_unit pie_checker u_pie_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: verif/list_reply_checker.sv
`timescale 1ns / 100ps

module list_reply_checker
    import pie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // [6:0] position, [38:7] value, [39] zero
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [31:0] data, [38:32] count, [39] zero
    input  logic [1:0]  m_tuser,   // [1:0] status
    output int          fail_count,
    output int          awaited,
    output int          list_fill,
    output int          replies_checked,
    output int          full_hits,
    output int          empty_hits,
    output int          range_hits,
    output int          peak_fill
);

    typedef struct packed {
        status_t            status;
        logic [VAL_W-1:0]   data;
        logic [POS_W-1:0]   count;
    } reply_t;

    reply_t           awaited_replies[$];
    logic [VAL_W-1:0] cells [CAPACITY];
    int               fill;

    // Carry out one request on the shadow list and return the reply it owes.
    function automatic reply_t apply_list_request(input logic [2:0] kind, input int pos,
                                                  input logic [VAL_W-1:0] v);
        reply_t r;
        int     i;
        r.status = ST_OK;
        r.data   = '0;
        case (kind)
            REQ_INSERT, REQ_PUSH:
            begin
                if (kind == REQ_PUSH)
                    pos = fill;
                if (pos > fill)
                    r.status = ST_RANGE;
                else if (fill >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (i = fill; i > pos; i--)
                        cells[i] = cells[i - 1];
                    cells[pos] = v;
                    fill++;
                end
            end
            REQ_ERASE, REQ_POP, REQ_READ:
            begin
                if (kind == REQ_POP)
                    pos = fill - 1;
                if (fill == 0)
                    r.status = ST_EMPTY;
                else if (pos >= fill)
                    r.status = ST_RANGE;
                else
                begin
                    r.data = cells[pos];
                    if (kind != REQ_READ)
                    begin
                        for (i = pos; i + 1 < fill; i++)
                            cells[i] = cells[i + 1];
                        fill--;
                    end
                end
            end
            default:
                ;
        endcase
        r.count = fill[POS_W-1:0];
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            fill = 0;
            awaited_replies.delete();
            fail_count      = 0;
            replies_checked = 0;
            full_hits       = 0;
            empty_hits      = 0;
            range_hits      = 0;
            peak_fill       = 0;
            awaited   <= 0;
            list_fill <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_replies.size() == 0)
                    note_mismatch("unexpected reply", '0, m_tdata[31:0]);
                else
                begin
                    want = awaited_replies.pop_front();
                    replies_checked++;
                    if (m_tuser !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(m_tuser));
                    if (m_tdata[31:0] !== want.data)
                        note_mismatch("data", want.data, m_tdata[31:0]);
                    if (m_tdata[38:32] !== want.count)
                        note_mismatch("count", 32'(want.count), 32'(m_tdata[38:32]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = apply_list_request(s_tuser, 32'(s_tdata[6:0]), s_tdata[38:7]);
                case (want.status)
                    ST_FULL:  full_hits++;
                    ST_EMPTY: empty_hits++;
                    ST_RANGE: range_hits++;
                    default:  ;
                endcase
                if (fill > peak_fill)
                    peak_fill = fill;
                awaited_replies.push_back(want);
            end
            // publish by nonblocking update so the stimulus side reads a settled value
            awaited   <= awaited_replies.size();
            list_fill <= fill;
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import pie_pkg::*;

    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;
    localparam int         RANDOM_REQUESTS = 1830;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        steady   = 1'b0;

    int fail_count;
    int awaited;
    int list_fill;
    int replies_checked;
    int full_hits;
    int empty_hits;
    int range_hits;
    int peak_fill;

    always #2 clk = ~clk;

    positional_insert_erase_list_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    list_reply_checker u_reply_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .awaited         (awaited),
        .list_fill       (list_fill),
        .replies_checked (replies_checked),
        .full_hits       (full_hits),
        .empty_hits      (empty_hits),
        .range_hits      (range_hits),
        .peak_fill       (peak_fill)
    );

    // Stall the reply side at random, except through the steady stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= steady || ($urandom_range(0, 99) >= 36);
    end

    task automatic send_request(input logic [2:0] kind, input logic [6:0] pos,
                                input logic [31:0] v);
        while (!steady && $urandom_range(0, 99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, v, pos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly land inside the list or just past its end; now and then anywhere.
    function automatic logic [6:0] pick_position(input int len);
        if ($urandom_range(0, 99) < 82)
            return 7'($urandom_range(0, len));
        return 7'($urandom_range(0, 127));
    endfunction

    initial
    begin
        int         sent;
        int         phase_left;
        int         r;
        bit         growing;
        logic [2:0] kind;

        sent       = 0;
        phase_left = 0;
        growing    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every removal and read must report empty
        send_request(REQ_POP, 7'd0, 32'h0);
        send_request(REQ_ERASE, 7'd127, 32'h0);
        send_request(REQ_READ, 7'd0, 32'h0);
        send_request(REQ_INSERT, 7'd1, 32'h0000_1234);
        send_request(REQ_INSERT, 7'd0, 32'h8000_0000);
        send_request(REQ_PUSH, 7'd127, 32'h7FFF_FFFF);
        send_request(REQ_INSERT, 7'd1, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 7'd3, 32'h0000_0000);
        send_request(REQ_INSERT, 7'd127, 32'h5A5A_A5A5);
        send_request(REQ_READ, 7'd0, 32'h0);
        send_request(REQ_READ, 7'd3, 32'h0);
        send_request(REQ_READ, 7'd4, 32'h0);
        send_request(REQ_READ, 7'd127, 32'h0);
        send_request(REQ_ERASE, 7'd1, 32'h0);
        send_request(REQ_ERASE, 7'd5, 32'h0);
        send_request(REQ_POP, 7'd99, 32'hFFFF_FFFF);
        for (int k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++)
            send_request(k[2:0], 7'($urandom_range(0, 127)), $urandom);
        send_request(REQ_ERASE, 7'd0, 32'h0);
        send_request(REQ_POP, 7'd0, 32'h0);
        send_request(REQ_POP, 7'd0, 32'h0);

        // alternate growing and shrinking phases so full and empty are both reached
        while (sent < RANDOM_REQUESTS)
        begin
            if (phase_left == 0)
            begin
                growing    = !growing;
                phase_left = $urandom_range(60, 160);
            end
            steady <= (sent >= 800 && sent < 1100);
            r = $urandom_range(0, 99);
            if (r < 3)
                kind = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
            else if (growing)
                kind = (r < 45) ? REQ_INSERT : (r < 70) ? REQ_PUSH :
                       (r < 78) ? REQ_ERASE  : (r < 85) ? REQ_POP  : REQ_READ;
            else
                kind = (r < 10) ? REQ_INSERT : (r < 18) ? REQ_PUSH :
                       (r < 50) ? REQ_ERASE  : (r < 78) ? REQ_POP  : REQ_READ;
            send_request(kind, pick_position(list_fill), pick_value());
            if (kind <= REQ_READ)
            begin
                sent++;
                phase_left--;
            end
        end
        s_tvalid <= 1'b0;
        steady   <= 1'b0;

        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("summary: %0d replies checked, list depth peaked at %0d of %0d",
                 replies_checked, peak_fill, CAPACITY);
        $display("summary: %0d full, %0d empty and %0d out-of-range refusals seen",
                 full_hits, empty_hits, range_hits);
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
